// ----- src/wse_pkg.sv -----
`default_nettype none
package wse_pkg;

  localparam int unsigned SYMBOL_COUNT = 162;

  localparam logic [31:0] POLY_FIRST  = 32'hF2D05351;
  localparam logic [31:0] POLY_SECOND = 32'hE4613C47;

  // Sync vector, position 0 first.
  localparam logic [0:161] SYNC_PATTERN = {
    32'b11000000_10001110_00100101_11100000,
    32'b00100101_00000010_11001101_00011010,
    32'b00011010_10101001_00101100_01101010,
    32'b00100000_10010011_10110011_01000111,
    32'b00000101_00110000_00011010_11000110,
    2'b00
  };

  typedef logic [27:0] acc_t;
  typedef logic [21:0] locpwr_t;
  typedef logic [49:0] message_t;

  typedef enum logic [1:0] {
    REG_CALLSIGN = 2'd0,
    REG_LOCATOR  = 2'd1,
    REG_POWER    = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PACK,
    ST_COUNT,
    ST_SHIFT,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    STEP_N0, STEP_N1, STEP_N2, STEP_N3, STEP_N4, STEP_N5,
    STEP_M0, STEP_M1, STEP_M2, STEP_M3, STEP_M4
  } mac_step_t;

  typedef struct packed {
    logic       bad;
    logic [5:0] value;
  } char_code_t;

  typedef struct packed {
    logic [5:0][5:0] call;
    logic [3:0][5:0] loc;
    logic            bad;
  } char_set_t;

  function automatic char_code_t char_value(input logic [7:0] c);
    char_code_t r;
    r.bad   = 1'b0;
    r.value = 6'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 6'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r.value = 6'(c - 8'h41 + 8'd10);
    end else if (c == 8'h20) begin
      r.value = 6'd36;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [7:0] reverse8(input logic [7:0] x);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = x[k];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/wse_ifs.sv -----
`default_nettype none
interface wse_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_position;
  modport source(output valid, output symbol_position, input ready);
  modport sink(input valid, input symbol_position, output ready);
endinterface

interface wse_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] channel_symbol;
  logic       bad_character;
  modport source(output valid, output channel_symbol, output bad_character, input ready);
  modport sink(input valid, input channel_symbol, input bad_character, output ready);
endinterface

interface wse_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [47:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- src/wse_char_decode.sv -----
`default_nettype none
module wse_char_decode (
  input  wire logic [47:0]        callsign_text,
  input  wire logic [31:0]        locator_text,
  output wse_pkg::char_set_t      chars
);

  wse_pkg::char_code_t call_code [6];
  wse_pkg::char_code_t loc_code [4];

  always_comb begin
    chars.bad = 1'b0;
    for (int k = 0; k < 6; k++) begin
      call_code[k]  = wse_pkg::char_value(callsign_text[8*(5-k) +: 8]);
      chars.call[k] = call_code[k].value;
      chars.bad     = chars.bad | call_code[k].bad;
    end
    for (int k = 0; k < 4; k++) begin
      loc_code[k]  = wse_pkg::char_value(locator_text[8*(3-k) +: 8]);
      chars.loc[k] = loc_code[k].value;
      chars.bad    = chars.bad | loc_code[k].bad;
    end
  end

endmodule
`default_nettype wire

// ----- src/wse_mac.sv -----
`default_nettype none
module wse_mac (
  input  wire wse_pkg::acc_t acc,
  input  wire logic [7:0]    mult,
  input  wire wse_pkg::acc_t addend,
  output wse_pkg::acc_t      result
);

  logic [35:0] product;

  // Everything downstream is taken modulo 2^28 or less, so the product wraps.
  assign product = acc * mult;
  assign result  = product[27:0] + addend;

endmodule
`default_nettype wire

// ----- src/wspr_symbol_encoder_core.sv -----
`default_nettype none
// WSPR channel symbol encoder. Write the callsign, locator and power registers while idle,
// then request any of the 162 positions; each request returns one 4-FSK tone and the
// invalid-character flag. A request runs on one shared multiply-add unit that packs the
// call and locator/power words, then a counter walks the bit-reversed interleaver indices
// below the reversed position, then the coder register shifts in message bits up to the
// message bit index (half the coded bit's index), then the done state loads the output
// register once it is free. The next request is taken only after that, back in idle.
// Requests for an invalid message or a position past 161 go straight to the done state,
// which loads tone 0. The result waits in an output register, so a new request is taken
// while it is unclaimed.
module wspr_symbol_encoder_core (
  input  wire logic clk,
  input  wire logic rst,
  wse_cfg_if.sink   cfg,
  wse_req_if.sink   req,
  wse_res_if.source res
);

  logic [47:0] callsign_text;
  logic [31:0] locator_text;
  logic [5:0]  power_dbm;

  wse_pkg::char_set_t chars;

  wse_pkg::state_t    state, state_next;
  wse_pkg::mac_step_t step, step_next;
  wse_pkg::acc_t      acc, acc_next;
  wse_pkg::acc_t      call_word, call_word_next;
  wse_pkg::locpwr_t   locpwr_word, locpwr_word_next;
  wse_pkg::message_t  message, message_next;
  logic [7:0]         pos, pos_next;
  logic               zero_sym, zero_sym_next;
  logic [7:0]         scan, scan_next;
  logic [7:0]         coded_index, coded_index_next;
  logic [6:0]         shift_count, shift_count_next;
  logic [31:0]        conv, conv_next;
  logic               out_valid, out_valid_next;
  logic [1:0]         out_symbol, out_symbol_next;
  logic               out_bad, out_bad_next;

  logic [7:0]         mac_mult;
  wse_pkg::acc_t      mac_addend;
  wse_pkg::acc_t      mac_result;
  logic [31:0]        poly;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      callsign_text <= '0;
      locator_text  <= '0;
      power_dbm     <= '0;
    end else if (cfg.valid) begin
      unique case (wse_pkg::reg_index_t'(cfg.index))
        wse_pkg::REG_CALLSIGN: callsign_text <= cfg.data;
        wse_pkg::REG_LOCATOR:  locator_text  <= cfg.data[31:0];
        wse_pkg::REG_POWER:    power_dbm     <= cfg.data[5:0];
        default: ;
      endcase
    end
  end

  wse_char_decode u_decode (
    .callsign_text(callsign_text),
    .locator_text (locator_text),
    .chars        (chars)
  );

  // Packing schedule: N = c0, *36+c1, *10+c2, *27+c3-10 ...; M is rewritten as
  // ((10-l0)*10 + 179-l2)*18 + l1-10, *10+l3, *128+power+64, all modulo the word width.
  always_comb begin
    unique case (step)
      wse_pkg::STEP_N0: begin
        mac_mult   = 8'd0;
        mac_addend = wse_pkg::acc_t'(chars.call[0]);
      end
      wse_pkg::STEP_N1: begin
        mac_mult   = 8'd36;
        mac_addend = wse_pkg::acc_t'(chars.call[1]);
      end
      wse_pkg::STEP_N2: begin
        mac_mult   = 8'd10;
        mac_addend = wse_pkg::acc_t'(chars.call[2]);
      end
      wse_pkg::STEP_N3: begin
        mac_mult   = 8'd27;
        mac_addend = wse_pkg::acc_t'(chars.call[3]) - wse_pkg::acc_t'(10);
      end
      wse_pkg::STEP_N4: begin
        mac_mult   = 8'd27;
        mac_addend = wse_pkg::acc_t'(chars.call[4]) - wse_pkg::acc_t'(10);
      end
      wse_pkg::STEP_N5: begin
        mac_mult   = 8'd27;
        mac_addend = wse_pkg::acc_t'(chars.call[5]) - wse_pkg::acc_t'(10);
      end
      wse_pkg::STEP_M0: begin
        mac_mult   = 8'd0;
        mac_addend = wse_pkg::acc_t'(10) - wse_pkg::acc_t'(chars.loc[0]);
      end
      wse_pkg::STEP_M1: begin
        mac_mult   = 8'd10;
        mac_addend = wse_pkg::acc_t'(179) - wse_pkg::acc_t'(chars.loc[2]);
      end
      wse_pkg::STEP_M2: begin
        mac_mult   = 8'd18;
        mac_addend = wse_pkg::acc_t'(chars.loc[1]) - wse_pkg::acc_t'(10);
      end
      wse_pkg::STEP_M3: begin
        mac_mult   = 8'd10;
        mac_addend = wse_pkg::acc_t'(chars.loc[3]);
      end
      wse_pkg::STEP_M4: begin
        mac_mult   = 8'd128;
        mac_addend = wse_pkg::acc_t'(power_dbm) + wse_pkg::acc_t'(64);
      end
      default: begin
        mac_mult   = 8'd0;
        mac_addend = '0;
      end
    endcase
  end

  wse_mac u_mac (
    .acc   (acc),
    .mult  (mac_mult),
    .addend(mac_addend),
    .result(mac_result)
  );

  assign poly = coded_index[0] ? wse_pkg::POLY_SECOND : wse_pkg::POLY_FIRST;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wse_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    step        <= step_next;
    acc         <= acc_next;
    call_word   <= call_word_next;
    locpwr_word <= locpwr_word_next;
    message     <= message_next;
    pos         <= pos_next;
    zero_sym    <= zero_sym_next;
    scan        <= scan_next;
    coded_index <= coded_index_next;
    shift_count <= shift_count_next;
    conv        <= conv_next;
    out_symbol  <= out_symbol_next;
    out_bad     <= out_bad_next;
  end

  always_comb begin
    state_next       = state;
    step_next        = step;
    acc_next         = acc;
    call_word_next   = call_word;
    locpwr_word_next = locpwr_word;
    message_next     = message;
    pos_next         = pos;
    zero_sym_next    = zero_sym;
    scan_next        = scan;
    coded_index_next = coded_index;
    shift_count_next = shift_count;
    conv_next        = conv;
    out_valid_next   = out_valid;
    out_symbol_next  = out_symbol;
    out_bad_next     = out_bad;

    if (out_valid && res.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      wse_pkg::ST_IDLE: begin
        if (req.valid) begin
          pos_next      = req.symbol_position;
          zero_sym_next = chars.bad ||
                          (req.symbol_position >= 8'(wse_pkg::SYMBOL_COUNT));
          step_next     = wse_pkg::STEP_N0;
          acc_next      = '0;
          state_next    = zero_sym_next ? wse_pkg::ST_DONE : wse_pkg::ST_PACK;
        end
      end
      wse_pkg::ST_PACK: begin
        acc_next = mac_result;
        if (step == wse_pkg::STEP_N5) begin
          call_word_next = mac_result;
        end
        if (step == wse_pkg::STEP_M4) begin
          locpwr_word_next = mac_result[21:0];
          scan_next        = '0;
          coded_index_next = '0;
          state_next       = wse_pkg::ST_COUNT;
        end else begin
          step_next = wse_pkg::mac_step_t'(step + 4'd1);
        end
      end
      wse_pkg::ST_COUNT: begin
        // The coded-bit index is the number of interleaver counters below the
        // reversed position whose own reversal lands inside the frame.
        if (scan == wse_pkg::reverse8(pos)) begin
          message_next     = {call_word, locpwr_word};
          conv_next        = '0;
          shift_count_next = '0;
          state_next       = wse_pkg::ST_SHIFT;
        end else begin
          if (wse_pkg::reverse8(scan) < 8'(wse_pkg::SYMBOL_COUNT)) begin
            coded_index_next = coded_index + 8'd1;
          end
          scan_next = scan + 8'd1;
        end
      end
      wse_pkg::ST_SHIFT: begin
        // Zeros follow the 50 message bits, which gives the tail for free.
        conv_next    = {conv[30:0], message[49]};
        message_next = {message[48:0], 1'b0};
        if (shift_count == coded_index[7:1]) begin
          state_next = wse_pkg::ST_DONE;
        end else begin
          shift_count_next = shift_count + 7'd1;
        end
      end
      wse_pkg::ST_DONE: begin
        if (!out_valid || res.ready) begin
          out_valid_next  = 1'b1;
          out_symbol_next = zero_sym ? 2'b00 :
                            {^(conv & poly), wse_pkg::SYNC_PATTERN[pos]};
          out_bad_next    = chars.bad;
          state_next      = wse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wse_pkg::ST_IDLE;
      end
    endcase
  end

  assign req.ready          = (state == wse_pkg::ST_IDLE);
  assign res.valid          = out_valid;
  assign res.channel_symbol = out_symbol;
  assign res.bad_character  = out_bad;

endmodule
`default_nettype wire

// ----- src/wse_checker.sv -----
`default_nettype none
module wse_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [1:0] res_symbol,
  input wire logic       res_bad
);

  // A result stays offered until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before transfer");

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_symbol) && $stable(res_bad))
    else $error("result payload changed while stalled");

  // An accepted request takes the encoder out of idle, so ready drops behind it.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while the previous one is still in work");

  // An invalid message always gives tone zero.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_bad |-> res_symbol == 2'b00)
    else $error("nonzero tone reported with a bad character");

endmodule

bind wspr_symbol_encoder_core wse_checker u_wse_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_symbol(res.channel_symbol),
  .res_bad   (res.bad_character)
);
`default_nettype wire
